[src/crs3_pkg.sv]
//------------------------------------------------------------------------------
// crs3_pkg
// Shared types and constants for the 3x3 Cramer solver.
//------------------------------------------------------------------------------
`default_nettype none
package crs3_pkg;
  localparam int CoefW = 16;
  localparam int ProdW = 32;
  localparam int DetW  = 52;
  localparam int SolW  = 32;
  localparam int MagW  = 49;          // |det| < 2^48
  localparam int NumW  = MagW + 16;   // dividend scaled by 2^16
  localparam int QW    = 33;          // quotient bits kept (saturation detect)

  localparam logic [1:0] ST_UNIQUE   = 2'd0;
  localparam logic [1:0] ST_INFINITE = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;

  typedef struct packed {
    logic signed [CoefW-1:0] r1_cx;
    logic signed [CoefW-1:0] r1_cy;
    logic signed [CoefW-1:0] r1_cz;
    logic signed [CoefW-1:0] r1_rhs;
    logic signed [CoefW-1:0] r2_cx;
    logic signed [CoefW-1:0] r2_cy;
    logic signed [CoefW-1:0] r2_cz;
    logic signed [CoefW-1:0] r2_rhs;
    logic signed [CoefW-1:0] r3_cx;
    logic signed [CoefW-1:0] r3_cy;
    logic signed [CoefW-1:0] r3_cz;
    logic signed [CoefW-1:0] r3_rhs;
  } in_req_t;

  typedef struct packed {
    logic signed [DetW-1:0] det_main;
    logic signed [DetW-1:0] det_x;
    logic signed [DetW-1:0] det_y;
    logic signed [DetW-1:0] det_z;
    logic signed [SolW-1:0] sol_x;
    logic signed [SolW-1:0] sol_y;
    logic signed [SolW-1:0] sol_z;
    logic [1:0]             status;
    logic                   saturated;
  } out_res_t;

  typedef logic signed [DetW-1:0] det_t;
  typedef det_t [3:0] det4_t;
endpackage
`default_nettype wire

[src/crs3_det.sv]
//------------------------------------------------------------------------------
// crs3_det
// Four 3x3 determinants by cofactor expansion, three register stages.
//------------------------------------------------------------------------------
`default_nettype none
module crs3_det (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire crs3_pkg::in_req_t in_req,
  output logic                 out_vld,
  output crs3_pkg::det4_t      out_det
);
  import crs3_pkg::*;

  // stage 1: 2x2 minors from rows 2/3 (columns: x y z rhs)
  logic signed [CoefW-1:0] a0 [4];
  logic signed [CoefW-1:0] b1 [4];
  logic signed [CoefW-1:0] b2 [4];
  logic signed [ProdW:0] mn_r [4][4];   // mn_r[i][j] = b1[i]*b2[j]-b1[j]*b2[i]
  logic signed [CoefW-1:0] a0_r [4];
  logic v1_r, v2_r, v3_r;

  assign a0 = '{in_req.r1_cx, in_req.r1_cy, in_req.r1_cz, in_req.r1_rhs};
  assign b1 = '{in_req.r2_cx, in_req.r2_cy, in_req.r2_cz, in_req.r2_rhs};
  assign b2 = '{in_req.r3_cx, in_req.r3_cy, in_req.r3_cz, in_req.r3_rhs};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      a0_r[i] <= a0[i];
      for (int j = 0; j < 4; j++)
        mn_r[i][j] <= (ProdW+1)'(b1[i] * b2[j]) - (ProdW+1)'(b1[j] * b2[i]);
    end
  end

  // stage 2: first-row products, sign folded in
  // det(c0,c1,c2) = a[c0]*M[c1][c2] - a[c1]*M[c0][c2] + a[c2]*M[c0][c1]
  logic signed [DetW-1:0] pr_r [4][3];
  localparam int C [4][3] = '{'{0,1,2}, '{3,1,2}, '{0,3,2}, '{0,1,3}};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pr_r[k][0] <= DetW'(a0_r[C[k][0]] * mn_r[C[k][1]][C[k][2]]);
      pr_r[k][1] <= -DetW'(a0_r[C[k][1]] * mn_r[C[k][0]][C[k][2]]);
      pr_r[k][2] <= DetW'(a0_r[C[k][2]] * mn_r[C[k][0]][C[k][1]]);
    end
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++)
      out_det[k] <= pr_r[k][0] + pr_r[k][1] + pr_r[k][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r;
    end
  end
  assign out_vld = v3_r;
endmodule
`default_nettype wire

[src/crs3_div.sv]
//------------------------------------------------------------------------------
// crs3_div
// Pipelined restoring divider: |num|*2^16 / |den|, one quotient bit per stage,
// then sign and Q16.16 clamp. Register stages in order: entry, overflow check, QW bit
// stages, clamp.
//------------------------------------------------------------------------------
`default_nettype none
module crs3_div (
  input  wire logic                       clk,
  input  wire logic signed [crs3_pkg::DetW-1:0] num,
  input  wire logic signed [crs3_pkg::DetW-1:0] den,
  output logic signed [crs3_pkg::SolW-1:0] quo,
  output logic                            sat
);
  import crs3_pkg::*;

  // entry stage: magnitudes
  logic [NumW-1:0] n0_r;
  logic [MagW-1:0] d0_r;
  logic            neg0_r;
  always_ff @(posedge clk) begin
    n0_r   <= {(num[DetW-1] ? MagW'(-num) : MagW'(num)), 16'd0};
    d0_r   <= den[DetW-1] ? MagW'(-den) : MagW'(den);
    neg0_r <= num[DetW-1] ^ den[DetW-1];
  end

  // iterative stages; high quotient bits beyond QW fold into an overflow flag
  localparam int HiBits = NumW - QW;
  logic [MagW:0]   rem_r [QW+1];
  logic [NumW-1:0] nsh_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [MagW-1:0] d_r   [QW+1];
  logic            neg_r [QW+1];
  logic            ovf_r [QW+1];

  // high part: quotient bits above QW-1 nonzero iff n_hi >= d
  logic [HiBits-1:0] nhi;
  assign nhi = n0_r[NumW-1 -: HiBits];
  always_ff @(posedge clk) begin
    ovf_r[0] <= ({{(MagW-HiBits){1'b0}}, nhi} >= d0_r);
    rem_r[0] <= {{(MagW+1-HiBits){1'b0}}, nhi};
    nsh_r[0] <= n0_r << HiBits;
    q_r[0]   <= '0;
    d_r[0]   <= d0_r;
    neg_r[0] <= neg0_r;
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [MagW:0] tr;
    logic          ge;
    assign tr = (rem_r[s] << 1) | (MagW+1)'(nsh_r[s][NumW-1]);
    assign ge = tr >= {1'b0, d_r[s]};
    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? tr - {1'b0, d_r[s]} : tr;
      nsh_r[s+1] <= nsh_r[s] << 1;
      q_r[s+1]   <= {q_r[s][QW-2:0], ge};
      d_r[s+1]   <= d_r[s];
      neg_r[s+1] <= neg_r[s];
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  // clamp
  logic [QW-1:0] qf;
  logic          big;
  assign qf  = q_r[QW];
  assign big = ovf_r[QW] || (neg_r[QW] ? (qf > QW'(33'h080000000))
                                        : (qf > QW'(33'h07FFFFFFF)));
  always_ff @(posedge clk) begin
    sat <= big;
    if (big)
      quo <= neg_r[QW] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else
      quo <= neg_r[QW] ? SolW'(-qf) : SolW'(qf);
  end
endmodule
`default_nettype wire

[src/cramer_rule_3x3_solver.sv]
//------------------------------------------------------------------------------
// cramer_rule_3x3_solver
// Solves a 3x3 Q8.8 linear system by Cramer's rule with Q16.16 results.
//------------------------------------------------------------------------------
// Usage:
//  - Present one augmented system on in_req and pulse start. busy is tied low,
//    so a request is taken every cycle that start is high: one system per
//    clock sustained.
//  - Each result appears on out_res for one cycle with out_valid high. The path
//    from the accepting edge to the out_valid cycle runs through 3 determinant
//    stages, 1 zero-check stage and the divider (entry, overflow check, 33
//    quotient-bit stages, clamp). The 33 per-bit subtract/compare stages of
//    the divider make up most of that path.
//  - The three quotients share den = det_main and run in three parallel
//    dividers; determinants and status ride a delay line alongside.
//  - Reset (rst_n low, synchronous) clears all valid bits; data regs are not
//    reset. The receiver cannot stall, so nothing backs up.
//------------------------------------------------------------------------------
`default_nettype none
module cramer_rule_3x3_solver (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire crs3_pkg::in_req_t   in_req,
  output logic                     out_valid,
  output crs3_pkg::out_res_t       out_res
);
  import crs3_pkg::*;

  localparam int DivLat = QW + 3;

  assign busy = 1'b0;

  // determinant pipeline
  logic  det_vld;
  det4_t det;
  crs3_det u_det (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy), .in_req(in_req),
    .out_vld(det_vld), .out_det(det)
  );

  // classify; feed dividers with den forced to 1 when singular (result unused)
  det4_t       dq_r;
  logic        vq_r;
  logic        sing_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    dq_r   <= det;
    sing_r <= (det[0] == '0);
    st_r   <= (det[0] != '0) ? ST_UNIQUE :
              ((det[1] == '0 && det[2] == '0 && det[3] == '0) ? ST_INFINITE : ST_NONE);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vq_r <= 1'b0;
    else        vq_r <= det_vld;
  end

  det_t den;
  assign den = sing_r ? DetW'(1) : dq_r[0];

  logic signed [SolW-1:0] q [3];
  logic                   s [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    crs3_div u_div (.clk(clk), .num(dq_r[i+1]), .den(den), .quo(q[i]), .sat(s[i]));
  end

  // side delay line for determinants, status and valid
  det4_t      dd_r [DivLat];
  logic [1:0] sd_r [DivLat];
  logic       vd_r [DivLat];
  always_ff @(posedge clk) begin
    dd_r[0] <= dq_r;
    sd_r[0] <= st_r;
    for (int i = 1; i < DivLat; i++) begin
      dd_r[i] <= dd_r[i-1];
      sd_r[i] <= sd_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivLat; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= vq_r;
      for (int i = 1; i < DivLat; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  logic uniq;
  assign uniq = (sd_r[DivLat-1] == ST_UNIQUE);
  always_comb begin
    out_res.det_main  = dd_r[DivLat-1][0];
    out_res.det_x     = dd_r[DivLat-1][1];
    out_res.det_y     = dd_r[DivLat-1][2];
    out_res.det_z     = dd_r[DivLat-1][3];
    out_res.sol_x     = uniq ? q[0] : '0;
    out_res.sol_y     = uniq ? q[1] : '0;
    out_res.sol_z     = uniq ? q[2] : '0;
    out_res.status    = sd_r[DivLat-1];
    out_res.saturated = uniq && (s[0] || s[1] || s[2]);
  end
  assign out_valid = vd_r[DivLat-1];

`ifndef ASSERT_OFF
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status != 2'd3))
    else $error("status code 3 produced");
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.det_main == '0 |-> out_res.status != ST_UNIQUE
      && !out_res.saturated)
    else $error("singular system marked unique or saturated");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    det_vld |-> ##(DivLat+1) out_valid)
    else $error("result lost in pipeline");
`endif
endmodule
`default_nettype wire
